// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/mtc_pkg.sv
// ---------------------------------------------------------------------------
// mtc_pkg
// Constants, types and triangle table logic for the tetra triangulator.
// ---------------------------------------------------------------------------
`default_nettype none
package mtc_pkg;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int INDEX_BITS_DEF = 10;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;
	localparam int EDGE_BITS = 6;
	localparam int N_TET = 5;
	localparam int N_SLOT = 2 * N_TET;
	localparam int DIV_STEPS = 3;

	// corner code -> b-part bits {z, y, x}
	localparam logic [2:0] CORNER_B [8] = '{3'd0, 3'd1, 3'd5, 3'd4, 3'd2, 3'd3, 3'd7, 3'd6};
	localparam logic [2:0] TETRAS [N_TET][4] = '{
		'{3'd0, 3'd1, 3'd4, 3'd3},
		'{3'd2, 3'd3, 3'd6, 3'd1},
		'{3'd5, 3'd4, 3'd1, 3'd6},
		'{3'd7, 3'd6, 3'd3, 3'd4},
		'{3'd4, 3'd6, 3'd3, 3'd1}
	};

	typedef logic [EDGE_BITS-1:0] edge_t;
	typedef logic [2:0][EDGE_BITS-1:0] tri_t;
	typedef struct packed {
		logic v0;
		logic v1;
		tri_t t0;
		tri_t t1;
	} tet_t;

	function automatic int div_stages(input int qbits);
		return (qbits + DIV_STEPS - 1) / DIV_STEPS;
	endfunction

	function automatic edge_t edge_of(input logic [2:0] p, input logic [2:0] q);
		return (p < q) ? {p, q} : {q, p};
	endfunction

	function automatic tri_t mk(input logic [2:0] p0, input logic [2:0] q0,
			input logic [2:0] p1, input logic [2:0] q1,
			input logic [2:0] p2, input logic [2:0] q2);
		tri_t r;
		r[0] = edge_of(p0, q0);
		r[1] = edge_of(p1, q1);
		r[2] = edge_of(p2, q2);
		return r;
	endfunction

	// n = {nd, nc, nb, na}
	function automatic tet_t tetra_tris(input logic [3:0] n, input logic [2:0] a,
			input logic [2:0] b, input logic [2:0] c, input logic [2:0] d, input logic g);
		tet_t r;
		logic ab, ac, ad, bc, bd, cd;
		ab = n[0] ^ n[1];
		ac = n[0] ^ n[2];
		ad = n[0] ^ n[3];
		bc = n[1] ^ n[2];
		bd = n[1] ^ n[3];
		cd = n[2] ^ n[3];
		r = '0;
		if (ab || ac || ad) begin
			if (ab && ac && ad) begin
				r.v0 = 1'b1;
				r.t0 = (n[0] ^ g) ? mk(a, b, a, d, a, c) : mk(a, c, a, d, a, b);
			end else if (ab && bc && bd) begin
				r.v0 = 1'b1;
				r.t0 = (n[1] ^ g) ? mk(b, c, b, d, b, a) : mk(b, a, b, d, b, c);
			end else if (ac && bc && cd) begin
				r.v0 = 1'b1;
				r.t0 = (n[2] ^ g) ? mk(c, a, c, d, c, b) : mk(c, b, c, d, c, a);
			end else if (ad && bd && cd) begin
				r.v0 = 1'b1;
				r.t0 = (n[3] ^ g) ? mk(d, b, d, c, d, a) : mk(d, a, d, c, d, b);
			end else if (ab && bc && ad && cd) begin
				r.v0 = 1'b1;
				r.v1 = 1'b1;
				if (n[1] ^ g) begin
					r.t0 = mk(a, b, b, c, a, d);
					r.t1 = mk(b, c, c, d, a, d);
				end else begin
					r.t0 = mk(a, b, a, d, b, c);
					r.t1 = mk(b, c, a, d, c, d);
				end
			end else if (ad && ac && bc && bd) begin
				r.v0 = 1'b1;
				r.v1 = 1'b1;
				if (n[1] ^ g) begin
					r.t0 = mk(a, c, b, c, b, d);
					r.t1 = mk(a, c, b, d, a, d);
				end else begin
					r.t0 = mk(a, c, b, d, b, c);
					r.t1 = mk(a, c, a, d, b, d);
				end
			end else if (ab && ac && bd && cd) begin
				r.v0 = 1'b1;
				r.v1 = 1'b1;
				if (n[1] ^ g) begin
					r.t0 = mk(a, b, a, c, c, d);
					r.t1 = mk(a, b, c, d, b, d);
				end else begin
					r.t0 = mk(a, b, c, d, a, c);
					r.t1 = mk(a, b, b, d, c, d);
				end
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: hdl/mtc_cube_if.sv
// ---------------------------------------------------------------------------
// mtc_cube_if
// Cube channel: grid index and eight corner samples.
// ---------------------------------------------------------------------------
`default_nettype none
interface mtc_cube_if #(
	parameter int INDEX_BITS = mtc_pkg::INDEX_BITS_DEF,
	parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF
);
	logic valid;
	logic ready;
	logic [INDEX_BITS-1:0] cube_x;
	logic [INDEX_BITS-1:0] cube_y;
	logic [INDEX_BITS-1:0] cube_z;
	logic signed [SAMPLE_BITS-1:0] s000;
	logic signed [SAMPLE_BITS-1:0] s100;
	logic signed [SAMPLE_BITS-1:0] s010;
	logic signed [SAMPLE_BITS-1:0] s110;
	logic signed [SAMPLE_BITS-1:0] s001;
	logic signed [SAMPLE_BITS-1:0] s101;
	logic signed [SAMPLE_BITS-1:0] s011;
	logic signed [SAMPLE_BITS-1:0] s111;
	modport source(output valid, cube_x, cube_y, cube_z, s000, s100, s010, s110,
		s001, s101, s011, s111, input ready);
	modport sink(input valid, cube_x, cube_y, cube_z, s000, s100, s010, s110,
		s001, s101, s011, s111, output ready);
endinterface
`default_nettype wire

// File: hdl/mtc_tri_if.sv
// ---------------------------------------------------------------------------
// mtc_tri_if
// Triangle channel: cube index, edge codes a, b, c with their weights, last flag.
// ---------------------------------------------------------------------------
`default_nettype none
interface mtc_tri_if #(
	parameter int INDEX_BITS = mtc_pkg::INDEX_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = mtc_pkg::WEIGHT_FRAC_BITS_DEF
);
	logic valid;
	logic ready;
	logic [INDEX_BITS-1:0] tri_cube_x;
	logic [INDEX_BITS-1:0] tri_cube_y;
	logic [INDEX_BITS-1:0] tri_cube_z;
	logic [mtc_pkg::EDGE_BITS-1:0] edge_a;
	logic [mtc_pkg::EDGE_BITS-1:0] edge_b;
	logic [mtc_pkg::EDGE_BITS-1:0] edge_c;
	logic [WEIGHT_FRAC_BITS:0] weight_a;
	logic [WEIGHT_FRAC_BITS:0] weight_b;
	logic [WEIGHT_FRAC_BITS:0] weight_c;
	logic last_tri;
	modport source(output valid, tri_cube_x, tri_cube_y, tri_cube_z, edge_a, edge_b,
		edge_c, weight_a, weight_b, weight_c, last_tri, input ready);
	modport sink(input valid, tri_cube_x, tri_cube_y, tri_cube_z, edge_a, edge_b,
		edge_c, weight_a, weight_b, weight_c, last_tri, output ready);
endinterface
`default_nettype wire

// File: hdl/mtc_div.sv
// ---------------------------------------------------------------------------
// mtc_div
// Pipelined restoring divider: round(|lo| * 2^F / |lo - hi|).
// ---------------------------------------------------------------------------
`default_nettype none
module mtc_div #(
	parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = mtc_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [SAMPLE_BITS-1:0] lo,
	input wire logic signed [SAMPLE_BITS-1:0] hi,
	output logic [WEIGHT_FRAC_BITS:0] weight
);
	localparam int QB = WEIGHT_FRAC_BITS + 1;
	localparam int K = mtc_pkg::DIV_STEPS;
	localparam int NS = mtc_pkg::div_stages(QB);
	localparam int RB = SAMPLE_BITS + 1;
	localparam int DB = SAMPLE_BITS + WEIGHT_FRAC_BITS + 1;

	logic [RB-1:0] rem_s [NS+1];
	logic [QB-1:0] low_s [NS+1];
	logic [RB-1:0] den_s [NS+1];
	logic [QB-1:0] q_s [NS+1];

	logic signed [RB-1:0] diff;
	logic signed [RB-1:0] lo_x;
	logic [RB-1:0] den0;
	logic [RB-1:0] num0;
	logic [DB-1:0] dvd0;

	always_comb begin
		lo_x = {lo[SAMPLE_BITS-1], lo};
		diff = lo_x - {hi[SAMPLE_BITS-1], hi};
		den0 = diff[RB-1] ? RB'(-diff) : RB'(diff);
		num0 = lo_x[RB-1] ? RB'(-lo_x) : RB'(lo_x);
		dvd0 = {num0, {WEIGHT_FRAC_BITS{1'b0}}} + DB'(den0 >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= RB'(dvd0[DB-1:QB]);
			low_s[0] <= dvd0[QB-1:0];
			den_s[0] <= den0;
			q_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= NS; j++) begin : g_stage
		logic [RB-1:0] rem_d;
		logic [QB-1:0] low_d;
		logic [QB-1:0] q_d;
		always_comb begin
			logic [RB:0] t;
			rem_d = rem_s[j-1];
			low_d = low_s[j-1];
			q_d = q_s[j-1];
			for (int k = 0; k < K; k++) begin
				if ((j - 1) * K + k < QB) begin
					t = {rem_d, low_d[QB-1]};
					if (t >= {1'b0, den_s[j-1]}) begin
						rem_d = RB'(t - {1'b0, den_s[j-1]});
						q_d = {q_d[QB-2:0], 1'b1};
					end else begin
						rem_d = t[RB-1:0];
						q_d = {q_d[QB-2:0], 1'b0};
					end
					low_d = {low_d[QB-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_d;
				low_s[j] <= low_d;
				den_s[j] <= den_s[j-1];
				q_s[j] <= q_d;
			end
		end
	end

	assign weight = q_s[NS];
endmodule
`default_nettype wire

// File: hdl/mtc_front.sv
// ---------------------------------------------------------------------------
// mtc_front
// Corner remap, tetrahedron triangle table and one-per-cycle triangle issue while en is high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mtc_front #(
	parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
	parameter int INDEX_BITS = mtc_pkg::INDEX_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	mtc_cube_if.sink cube_in,
	output logic v_s3,
	output logic last_s3,
	output mtc_pkg::tri_t tri_s3,
	output logic [INDEX_BITS-1:0] x_s3,
	output logic [INDEX_BITS-1:0] y_s3,
	output logic [INDEX_BITS-1:0] z_s3,
	output logic signed [SAMPLE_BITS-1:0] lo_s3 [3],
	output logic signed [SAMPLE_BITS-1:0] hi_s3 [3]
);
	localparam int NSL = mtc_pkg::N_SLOT;

	logic signed [SAMPLE_BITS-1:0] samp [8];
	logic signed [SAMPLE_BITS-1:0] cval_d [8];
	logic [2:0] flip;

	assign samp[0] = cube_in.s000;
	assign samp[1] = cube_in.s100;
	assign samp[2] = cube_in.s010;
	assign samp[3] = cube_in.s110;
	assign samp[4] = cube_in.s001;
	assign samp[5] = cube_in.s101;
	assign samp[6] = cube_in.s011;
	assign samp[7] = cube_in.s111;
	assign flip = {cube_in.cube_z[0], cube_in.cube_y[0], cube_in.cube_x[0]};

	always_comb begin
		logic [2:0] p;
		for (int i = 0; i < 8; i++) begin
			p = mtc_pkg::CORNER_B[i] ^ flip ^ 3'b100;
			cval_d[i] = '0;
			for (int s = 0; s < 8; s++) begin
				if (p == 3'(s)) cval_d[i] = cval_d[i] | samp[s];
			end
		end
	end

	// s1: remapped corners
	logic v_s1;
	logic g_s1;
	logic signed [SAMPLE_BITS-1:0] cval_s1 [8];
	logic [INDEX_BITS-1:0] x_s1, y_s1, z_s1;
	logic [7:0] neg_s1;

	// s2: triangle slots of the cube being issued
	logic [NSL-1:0] mask_s2;
	mtc_pkg::tri_t tri_s2 [NSL];
	logic signed [SAMPLE_BITS-1:0] cval_s2 [8];
	logic [INDEX_BITS-1:0] x_s2, y_s2, z_s2;

	logic s1_take;
	logic [NSL-1:0] mask_d;
	mtc_pkg::tri_t tri_d [NSL];
	logic [NSL-1:0] sel_oh;
	mtc_pkg::tri_t tri_pick;
	logic signed [SAMPLE_BITS-1:0] lo_d [3];
	logic signed [SAMPLE_BITS-1:0] hi_d [3];

	assign s1_take = v_s1 && en && ((mask_s2 & (mask_s2 - 1'b1)) == '0);
	assign cube_in.ready = !v_s1 || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cube_in.ready) begin
			v_s1 <= cube_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cube_in.valid && cube_in.ready) begin
			cval_s1 <= cval_d;
			g_s1 <= ^flip;
			x_s1 <= cube_in.cube_x;
			y_s1 <= cube_in.cube_y;
			z_s1 <= cube_in.cube_z;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) neg_s1[i] = cval_s1[i][SAMPLE_BITS-1];
	end

	always_comb begin
		mtc_pkg::tet_t r;
		for (int t = 0; t < mtc_pkg::N_TET; t++) begin
			r = mtc_pkg::tetra_tris({neg_s1[mtc_pkg::TETRAS[t][3]],
				neg_s1[mtc_pkg::TETRAS[t][2]], neg_s1[mtc_pkg::TETRAS[t][1]],
				neg_s1[mtc_pkg::TETRAS[t][0]]}, mtc_pkg::TETRAS[t][0],
				mtc_pkg::TETRAS[t][1], mtc_pkg::TETRAS[t][2], mtc_pkg::TETRAS[t][3], g_s1);
			mask_d[2*t] = r.v0;
			mask_d[2*t+1] = r.v1;
			tri_d[2*t] = r.t0;
			tri_d[2*t+1] = r.t1;
		end
	end

	assign sel_oh = mask_s2 & (~mask_s2 + 1'b1);

	always_comb begin
		tri_pick = '0;
		for (int i = 0; i < NSL; i++) begin
			if (sel_oh[i]) tri_pick = tri_pick | tri_s2[i];
		end
		for (int v = 0; v < 3; v++) begin
			lo_d[v] = '0;
			hi_d[v] = '0;
			for (int c = 0; c < 8; c++) begin
				if (tri_pick[v][5:3] == 3'(c)) lo_d[v] = lo_d[v] | cval_s2[c];
				if (tri_pick[v][2:0] == 3'(c)) hi_d[v] = hi_d[v] | cval_s2[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s2 <= '0;
			v_s3 <= 1'b0;
		end else begin
			if (s1_take) begin
				mask_s2 <= mask_d;
			end else if (en) begin
				mask_s2 <= mask_s2 & ~sel_oh;
			end
			if (en) begin
				v_s3 <= mask_s2 != '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			tri_s2 <= tri_d;
			cval_s2 <= cval_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
		end
		if (en) begin
			tri_s3 <= tri_pick;
			last_s3 <= (mask_s2 & ~sel_oh) == '0;
			lo_s3 <= lo_d;
			hi_s3 <= hi_d;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			z_s3 <= z_s2;
		end
	end

	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, !en, $stable(mask_s2) && $stable(v_s3))
	`ASSERT_NEXT(a_busy_keeps_cube, clk, arst_n, en && !$onehot0(mask_s2), mask_s2 != '0)
	`ASSERT_NEXT(a_issue_valid, clk, arst_n, en, v_s3 == ($past(mask_s2) != '0))
endmodule
`default_nettype wire

// File: hdl/marching_tetra_cube_triangulator.sv
// ---------------------------------------------------------------------------
// marching_tetra_cube_triangulator
// Splits a voxel cube into five tetrahedra and issues one triangle a beat while tri_out is not stalled.
//
//   channel  | dir | beat
//   ---------+-----+------------------------------------------------
//   cube_in  | in  | cube index + eight corner samples
//   tri_out  | out | cube index, edge codes a/b/c, Q1.F weights a/b/c, last
//
// A cube holds the issue stage until its last triangle is issued.
// The pipelined divider resolves three quotient bits per stage.
// Reset clears valid bits and the triangle slot mask only.
// A stalled tri_out freezes the whole pipeline; cube_in is still taken
// while the remap stage is empty.
// ---------------------------------------------------------------------------
`default_nettype none
module marching_tetra_cube_triangulator #(
	parameter int SAMPLE_BITS = mtc_pkg::SAMPLE_BITS_DEF,
	parameter int INDEX_BITS = mtc_pkg::INDEX_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = mtc_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	mtc_cube_if.sink cube_in,
	mtc_tri_if.source tri_out
);
	localparam int NS = mtc_pkg::div_stages(WEIGHT_FRAC_BITS + 1);

	logic en;
	logic v_s3, last_s3;
	mtc_pkg::tri_t tri_s3;
	logic [INDEX_BITS-1:0] x_s3, y_s3, z_s3;
	logic signed [SAMPLE_BITS-1:0] lo_s3 [3];
	logic signed [SAMPLE_BITS-1:0] hi_s3 [3];
	logic [WEIGHT_FRAC_BITS:0] wt [3];

	logic v_s [NS+1];
	logic last_s [NS+1];
	mtc_pkg::tri_t tri_s [NS+1];
	logic [INDEX_BITS-1:0] x_s [NS+1];
	logic [INDEX_BITS-1:0] y_s [NS+1];
	logic [INDEX_BITS-1:0] z_s [NS+1];

	assign en = !v_s[NS] || tri_out.ready;

	mtc_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.cube_in(cube_in),
		.v_s3(v_s3),
		.last_s3(last_s3),
		.tri_s3(tri_s3),
		.x_s3(x_s3),
		.y_s3(y_s3),
		.z_s3(z_s3),
		.lo_s3(lo_s3),
		.hi_s3(hi_s3)
	);

	for (genvar v = 0; v < 3; v++) begin : g_div
		mtc_div #(
			.SAMPLE_BITS(SAMPLE_BITS),
			.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
		) u_div (
			.clk(clk),
			.en(en),
			.lo(lo_s3[v]),
			.hi(hi_s3[v]),
			.weight(wt[v])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= NS; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s3;
			for (int j = 1; j <= NS; j++) v_s[j] <= v_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s[0] <= last_s3;
			tri_s[0] <= tri_s3;
			x_s[0] <= x_s3;
			y_s[0] <= y_s3;
			z_s[0] <= z_s3;
			for (int j = 1; j <= NS; j++) begin
				last_s[j] <= last_s[j-1];
				tri_s[j] <= tri_s[j-1];
				x_s[j] <= x_s[j-1];
				y_s[j] <= y_s[j-1];
				z_s[j] <= z_s[j-1];
			end
		end
	end

	assign tri_out.valid = v_s[NS];
	assign tri_out.tri_cube_x = x_s[NS];
	assign tri_out.tri_cube_y = y_s[NS];
	assign tri_out.tri_cube_z = z_s[NS];
	assign tri_out.edge_a = tri_s[NS][0];
	assign tri_out.edge_b = tri_s[NS][1];
	assign tri_out.edge_c = tri_s[NS][2];
	assign tri_out.weight_a = wt[0];
	assign tri_out.weight_b = wt[1];
	assign tri_out.weight_c = wt[2];
	assign tri_out.last_tri = last_s[NS];
endmodule
`default_nettype wire
